// ----- design/dcp_pkg.sv -----
// Shared types for the distance constraint projection pipeline.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dcp_pkg;

  // Per-stage pipeline control: advance enable and the valid bit entering the unit
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage

`default_nettype wire

// ----- design/dcp_isqrt.sv -----
// Pipelined integer square root, one root bit per register stage.
// Carries a sideband word alongside; uses dcp_pkg for the pipeline control struct.
`timescale 1ns / 1ps
`default_nettype none

module dcp_isqrt #(
  parameter int RW  = 68,
  parameter int SBW = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dcp_pkg::pipe_ctl_t ctl_i,
  input  logic [RW-1:0]      rad_i,
  input  logic [SBW-1:0]     sb_i,
  output logic               valid_o,
  output logic [RW/2-1:0]    root_o,
  output logic [SBW-1:0]     sb_o
);
  import dcp_pkg::*;

  localparam int RB = RW / 2;

  logic [RB:0]        vld_q;
  logic [RB+1:0]      rem_q  [RB+1];
  logic [RB-1:0]      root_q [RB+1];
  logic [RW-1:0]      x_q    [RB+1];
  logic [SBW-1:0]     sb_q   [RB+1];

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.en) begin
      vld_q <= {vld_q[RB-1:0], ctl_i.valid};
    end
  end

  // Entry register
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      x_q[0]    <= rad_i;
      sb_q[0]   <= sb_i;
    end
  end

  // One digit-by-digit step per stage
  for (genvar s = 1; s <= RB; s++) begin : g_step
    logic [RB+3:0] t;
    logic [RB+3:0] trial;
    logic          ge;
    logic [RB+3:0] r;

    always_comb begin
      t     = {rem_q[s-1], x_q[s-1][RW-1:RW-2]};
      trial = (RB+4)'({root_q[s-1], 2'b01});
      ge    = (t >= trial);
      r     = ge ? (t - trial) : t;
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q[s]  <= r[RB+1:0];
        root_q[s] <= {root_q[s-1][RB-2:0], ge};
        x_q[s]    <= {x_q[s-1][RW-3:0], 2'b00};
        sb_q[s]   <= sb_q[s-1];
      end
    end
  end

  assign valid_o = vld_q[RB];
  assign root_o  = root_q[RB];
  assign sb_o    = sb_q[RB];

endmodule

`default_nettype wire

// ----- design/dcp_udiv.sv -----
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor; flags quotients that do not fit. Uses dcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcp_udiv #(
  parameter int NW    = 66,
  parameter int DW    = 34,
  parameter int QW    = 34,
  parameter int LANES = 3,
  parameter int SBW   = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dcp_pkg::pipe_ctl_t          ctl_i,
  input  logic [LANES-1:0][NW-1:0]    num_i,
  input  logic [DW-1:0]               den_i,
  input  logic [SBW-1:0]              sb_i,
  output logic                        valid_o,
  output logic [LANES-1:0][QW-1:0]    quo_o,
  output logic [LANES-1:0]            ovf_o,
  output logic [SBW-1:0]              sb_o
);
  import dcp_pkg::*;

  localparam int HW = NW - QW;
  localparam int CW = HW + DW;

  logic [QW:0]                  vld_q;
  logic [LANES-1:0][DW-1:0]     rem_q [QW+1];
  logic [LANES-1:0][QW-1:0]     x_q   [QW+1];
  logic [LANES-1:0]             ovf_q [QW+1];
  logic [DW-1:0]                den_q [QW+1];
  logic [SBW-1:0]               sb_q  [QW+1];

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.en) begin
      vld_q <= {vld_q[QW-1:0], ctl_i.valid};
    end
  end

  // Entry: upper numerator bits seed the remainder; quotient overflows if they reach the divisor
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      for (int l = 0; l < LANES; l++) begin
        rem_q[0][l] <= DW'(num_i[l][NW-1:QW]);
        x_q[0][l]   <= num_i[l][QW-1:0];
        ovf_q[0][l] <= (CW'(num_i[l][NW-1:QW]) >= CW'(den_i));
      end
      den_q[0] <= den_i;
      sb_q[0]  <= sb_i;
    end
  end

  // One quotient bit per stage
  for (genvar s = 1; s <= QW; s++) begin : g_step
    logic [LANES-1:0][DW:0] t;
    logic [LANES-1:0][DW:0] r;
    logic [LANES-1:0]       ge;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        t[l]  = {rem_q[s-1][l], x_q[s-1][l][QW-1]};
        ge[l] = (t[l] >= {1'b0, den_q[s-1]});
        r[l]  = ge[l] ? (t[l] - {1'b0, den_q[s-1]}) : t[l];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        for (int l = 0; l < LANES; l++) begin
          rem_q[s][l] <= r[l][DW-1:0];
          x_q[s][l]   <= {x_q[s-1][l][QW-2:0], ge[l]};
        end
        ovf_q[s] <= ovf_q[s-1];
        den_q[s] <= den_q[s-1];
        sb_q[s]  <= sb_q[s-1];
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign quo_o   = x_q[QW];
  assign ovf_o   = ovf_q[QW];
  assign sb_o    = sb_q[QW];

endmodule

`default_nettype wire

// ----- design/distance_constraint_projection_unit.sv -----
// Distance constraint projection unit: top level of the pipeline.
// Uses dcp_pkg, dcp_isqrt (length) and dcp_udiv (correction and mass shares).
//
// Usage: one constraint enters per transaction on the s_axis channel (positions
// of A and B, inverse masses, rest length in tdata; pinned flags in tuser).
// One result leaves per transaction on the m_axis channel (corrected A and B
// in tdata; applied flag in tuser). Results come out in input order.
// Throughput: one transaction per cycle, sustained while m_axis_tready stays high.
// Path from acceptance to m_axis_tvalid: the input and square stages, the
// bit-serial square root stages and the two divider pipelines, one result bit
// per stage each, the stages between them and the output register.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When the receiver stalls, a skid register takes one more result and then
// the whole pipeline holds in place; nothing is dropped or repeated, and
// s_axis_tready returns as soon as the skid register drains.
`timescale 1ns / 1ps
`default_nettype none

module distance_constraint_projection_unit #(
  parameter int WORD_BITS = 32
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, inv_mass_a, inv_mass_b, rest_length, zero fill
  input  logic [((9*WORD_BITS-3+7)/8)*8-1:0]         s_axis_tdata,
  // fixed_a, fixed_b
  input  logic [1:0]                                 s_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // new_a_x, new_a_y, new_a_z, new_b_x, new_b_y, new_b_z, zero fill
  output logic [((6*WORD_BITS+7)/8)*8-1:0]           m_axis_tdata,
  // applied
  output logic [0:0]                                 m_axis_tuser
);
  import dcp_pkg::*;

  localparam int W    = WORD_BITS;
  localparam int OTW  = ((6*W+7)/8)*8;
  localparam int MW   = W - 1;           // masses, rest length
  localparam int DMW  = W + 1;           // |delta|
  localparam int SQW  = 2*DMW + 2;       // sum of squares, even
  localparam int RB   = SQW / 2;         // root width
  localparam int DFW  = W + 1;           // |L - rest|
  localparam int PW1  = DMW + DFW;
  localparam int CW   = W + 2;           // clamped correction
  localparam int PW2  = CW + MW;
  localparam logic [CW-1:0] CLIM = {1'b1, {(W+1){1'b0}}};

  typedef struct packed {
    logic [2:0][W-1:0]   a;
    logic [2:0][W-1:0]   b;
    logic [2:0]          dsgn;
    logic [2:0][DMW-1:0] dm;
    logic [MW-1:0]       wa;
    logic [MW-1:0]       wb;
    logic [W-1:0]        w;
    logic                fa;
    logic                fb;
    logic [MW-1:0]       rest;
  } sb1_t;

  typedef struct packed {
    logic [2:0][W-1:0]   a;
    logic [2:0][W-1:0]   b;
    logic [2:0]          neg;
    logic [MW-1:0]       wa;
    logic [MW-1:0]       wb;
    logic [W-1:0]        w;
    logic                fa;
    logic                fb;
    logic                zero;
  } sb2_t;

  typedef struct packed {
    logic [2:0][W-1:0]   a;
    logic [2:0][W-1:0]   b;
    logic [2:0]          neg;
    logic                fa;
    logic                fb;
    logic                zero;
  } sb3_t;

  typedef struct packed {
    logic                applied;
    logic [2:0][W-1:0]   nb;
    logic [2:0][W-1:0]   na;
  } res_t;

  function automatic logic [W-1:0] sat_word(input logic [W+2:0] v);
    if ((&v[W+2:W-1]) || (~|v[W+2:W-1])) begin
      return v[W-1:0];
    end else if (v[W+2]) begin
      return {1'b1, {(W-1){1'b0}}};
    end else begin
      return {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  // Global advance: the pipeline holds only while the skid register is full
  logic en;
  logic skid_v_q;
  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic sq_valid;
  logic d1_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q} <= '0;
      {v4_q, v5_q, v6_q, v7_q} <= '0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= sq_valid;
      v5_q <= v4_q;
      v6_q <= d1_valid;
      v7_q <= v6_q;
    end
  end

  // Stage 1: unpack, delta = B - A, magnitude and sign
  sb1_t s1_d, s1_q;
  logic signed [W:0] dlt [3];

  always_comb begin
    s1_d = '0;
    for (int i = 0; i < 3; i++) begin
      s1_d.a[i]    = s_axis_tdata[i*W +: W];
      s1_d.b[i]    = s_axis_tdata[(3+i)*W +: W];
      dlt[i]       = $signed({s1_d.b[i][W-1], s1_d.b[i]}) - $signed({s1_d.a[i][W-1], s1_d.a[i]});
      s1_d.dsgn[i] = dlt[i][W];
      s1_d.dm[i]   = dlt[i][W] ? DMW'(-dlt[i]) : DMW'(dlt[i]);
    end
    s1_d.wa   = s_axis_tdata[6*W +: MW];
    s1_d.wb   = s_axis_tdata[6*W+MW +: MW];
    s1_d.rest = s_axis_tdata[6*W+2*MW +: MW];
    s1_d.w    = W'(s1_d.wa) + W'(s1_d.wb);
    s1_d.fa   = s_axis_tuser[0];
    s1_d.fb   = s_axis_tuser[1];
  end

  // Stage 2: squares; stage 3: sum of squares
  sb1_t s2_q, s3_q;
  logic [2:0][2*DMW-1:0] sqp_q;
  logic [SQW-1:0]        sq_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s1_q;
      for (int i = 0; i < 3; i++) begin
        sqp_q[i] <= s1_q.dm[i] * s1_q.dm[i];
      end
      s3_q <= s2_q;
      sq_q <= SQW'(sqp_q[0]) + SQW'(sqp_q[1]) + SQW'(sqp_q[2]);
    end
  end

  // Length L = floor(sqrt(sum))
  logic [RB-1:0]      len;
  logic [$bits(sb1_t)-1:0] sq_sb;
  sb1_t               s3o;

  dcp_isqrt #(
    .RW  (SQW),
    .SBW ($bits(sb1_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   ('{en: en, valid: v3_q}),
    .rad_i   (sq_q),
    .sb_i    (s3_q),
    .valid_o (sq_valid),
    .root_o  (len),
    .sb_o    (sq_sb)
  );

  assign s3o = sb1_t'(sq_sb);

  // Stage 4: L - rest, divisor 2L, bypass decision
  sb2_t                s4_d, s4_q;
  logic [2:0][DMW-1:0] dm4_q;
  logic [DFW-1:0]      diffm_d, diffm_q;
  logic [CW-1:0]       den1_q;
  logic                dneg;
  logic [RB-1:0]       rdiff;

  always_comb begin
    dneg       = (len < RB'(s3o.rest));
    rdiff      = dneg ? (RB'(s3o.rest) - len) : (len - RB'(s3o.rest));
    diffm_d    = rdiff[DFW-1:0];
    s4_d.a     = s3o.a;
    s4_d.b     = s3o.b;
    s4_d.neg   = s3o.dsgn ^ {3{dneg}};
    s4_d.wa    = s3o.wa;
    s4_d.wb    = s3o.wb;
    s4_d.w     = s3o.w;
    s4_d.fa    = s3o.fa;
    s4_d.fb    = s3o.fb;
    s4_d.zero  = (len == '0) || (s3o.w == '0);
  end

  // Stage 5: |d| * |L - rest|
  sb2_t                s5_q;
  logic [2:0][PW1-1:0] prod1_q;
  logic [CW-1:0]       den1_5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q    <= s4_d;
      dm4_q   <= s3o.dm;
      diffm_q <= diffm_d;
      den1_q  <= {len[W:0], 1'b0};
      s5_q    <= s4_q;
      for (int i = 0; i < 3; i++) begin
        prod1_q[i] <= dm4_q[i] * diffm_q;
      end
      den1_5_q <= den1_q;
    end
  end

  // Correction c = |d| * |L - rest| / (2L)
  logic [2:0][CW-1:0]       q1;
  logic [2:0]               ovf1;
  logic [$bits(sb2_t)-1:0]  d1_sb;
  sb2_t                     s5o;

  dcp_udiv #(
    .NW    (PW1),
    .DW    (CW),
    .QW    (CW),
    .LANES (3),
    .SBW   ($bits(sb2_t))
  ) u_div_corr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   ('{en: en, valid: v5_q}),
    .num_i   (prod1_q),
    .den_i   (den1_5_q),
    .sb_i    (s5_q),
    .valid_o (d1_valid),
    .quo_o   (q1),
    .ovf_o   (ovf1),
    .sb_o    (d1_sb)
  );

  assign s5o = sb2_t'(d1_sb);

  // Stage 6: clamp c; stage 7: c * wA and c * wB
  sb2_t                s6_q;
  logic [2:0][CW-1:0]  c_q;
  sb3_t                s7_q;
  logic [5:0][PW2-1:0] prod2_q;
  logic [W-1:0]        w7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_q <= s5o;
      for (int i = 0; i < 3; i++) begin
        c_q[i] <= (ovf1[i] || (q1[i] > CLIM)) ? CLIM : q1[i];
      end
      s7_q.a    <= s6_q.a;
      s7_q.b    <= s6_q.b;
      s7_q.neg  <= s6_q.neg;
      s7_q.fa   <= s6_q.fa;
      s7_q.fb   <= s6_q.fb;
      s7_q.zero <= s6_q.zero;
      for (int i = 0; i < 3; i++) begin
        prod2_q[i]   <= c_q[i] * s6_q.wa;
        prod2_q[3+i] <= c_q[i] * s6_q.wb;
      end
      w7_q <= s6_q.w;
    end
  end

  // Mass shares: c * wA / W and c * wB / W
  logic                     d2_valid;
  logic [5:0][CW-1:0]       q2;
  logic [$bits(sb3_t)-1:0]  d2_sb;
  sb3_t                     s7o;

  dcp_udiv #(
    .NW    (PW2),
    .DW    (W),
    .QW    (CW),
    .LANES (6),
    .SBW   ($bits(sb3_t))
  ) u_div_share (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   ('{en: en, valid: v7_q}),
    .num_i   (prod2_q),
    .den_i   (w7_q),
    .sb_i    (s7_q),
    .valid_o (d2_valid),
    .quo_o   (q2),
    .ovf_o   (),
    .sb_o    (d2_sb)
  );

  assign s7o = sb3_t'(d2_sb);

  // Final: apply signed shares, saturate, honor pins and bypass
  res_t                res_d;
  logic signed [W+2:0] sha [3];
  logic signed [W+2:0] shb [3];
  logic signed [W+2:0] av  [3];
  logic signed [W+2:0] bv  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sha[i] = s7o.neg[i] ? -$signed({1'b0, q2[i]})   : $signed({1'b0, q2[i]});
      shb[i] = s7o.neg[i] ? -$signed({1'b0, q2[3+i]}) : $signed({1'b0, q2[3+i]});
      av[i]  = $signed({{3{s7o.a[i][W-1]}}, s7o.a[i]});
      bv[i]  = $signed({{3{s7o.b[i][W-1]}}, s7o.b[i]});
      res_d.na[i] = (s7o.fa || s7o.zero) ? s7o.a[i] : sat_word(av[i] + sha[i]);
      res_d.nb[i] = (s7o.fb || s7o.zero) ? s7o.b[i] : sat_word(bv[i] - shb[i]);
    end
    res_d.applied = !s7o.zero;
  end

  // Output register with one skid entry
  res_t out_q, skid_q;
  logic out_v_q;
  logic pop;
  logic push;

  assign pop  = out_v_q && m_axis_tready;
  assign push = en && d2_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop || !out_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_v_q || pop) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop || !out_v_q) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (!out_v_q || pop) begin
        out_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end
  end

  assign m_axis_tvalid   = out_v_q;
  assign m_axis_tdata    = OTW'({out_q.nb, out_q.na});
  assign m_axis_tuser[0] = out_q.applied;

endmodule

`default_nettype wire
